### rtl/bol_pkg.sv
// Package for the bounded ordered list: command, error and cell operation codes,
// plus default sizes. No dependencies; every other file of the block depends on it.
`default_nettype none

package bol_pkg;

   localparam int CAPACITY_DEF  = 64;
   localparam int WORD_BITS_DEF = 32;

   localparam int CMD_W = 3;
   localparam int ERR_W = 2;

   typedef logic [CMD_W-1:0] cmd_type;
   typedef logic [ERR_W-1:0] err_type;

   // Command codes of the request word.
   localparam cmd_type CMD_APPEND = 3'd0;
   localparam cmd_type CMD_REMOVE = 3'd1;
   localparam cmd_type CMD_INSERT = 3'd2;
   localparam cmd_type CMD_ERASE  = 3'd3;
   localparam cmd_type CMD_READ   = 3'd4;
   localparam cmd_type CMD_WRITE  = 3'd5;
   localparam cmd_type CMD_CLEAR  = 3'd6;

   // Error codes of the response word.
   localparam err_type ERR_OK    = 2'd0;
   localparam err_type ERR_EMPTY = 2'd1;
   localparam err_type ERR_RANGE = 2'd2;
   localparam err_type ERR_FULL  = 2'd3;

   // Operation broadcast to every cell of the chain.
   typedef logic [2:0] cell_op_type;

   localparam cell_op_type CELL_HOLD     = 3'd0;
   localparam cell_op_type CELL_WRITE    = 3'd1;
   localparam cell_op_type CELL_INSERT   = 3'd2;
   localparam cell_op_type CELL_ERASE    = 3'd3;
   localparam cell_op_type CELL_SNAP     = 3'd4;
   localparam cell_op_type CELL_RD_SHIFT = 3'd5;

endpackage

`default_nettype wire

### rtl/bol_req_if.sv
// Request channel of the bounded ordered list: valid/ready plus the command word.
// Depends on bol_pkg for the command type.
`default_nettype none

interface bol_req_if #(
   parameter int POS_W     = 7,
   parameter int WORD_BITS = bol_pkg::WORD_BITS_DEF
);
   logic                   valid;
   logic                   ready;
   bol_pkg::cmd_type       cmd;
   logic [POS_W-1:0]       position;
   logic [WORD_BITS-1:0]   data_word;

   modport source (output valid, output cmd, output position, output data_word,
                   input ready);
   modport sink   (input valid, input cmd, input position, input data_word,
                   output ready);
endinterface

`default_nettype wire

### rtl/bol_rsp_if.sv
// Response channel of the bounded ordered list: valid/ready plus the result word.
// Depends on bol_pkg for the error type.
`default_nettype none

interface bol_rsp_if #(
   parameter int POS_W     = 7,
   parameter int WORD_BITS = bol_pkg::WORD_BITS_DEF
);
   logic                   valid;
   logic                   ready;
   logic [WORD_BITS-1:0]   read_word;
   logic [POS_W-1:0]       element_count;
   bol_pkg::err_type       error_code;

   modport source (output valid, output read_word, output element_count,
                   output error_code, input ready);
   modport sink   (input valid, input read_word, input element_count,
                   input error_code, output ready);
endinterface

`default_nettype wire

### rtl/bol_cell.sv
// One storage cell of the list chain: holds one element and one read-chain stage.
// Depends on bol_pkg for the cell operation codes.
`default_nettype none

module bol_cell #(
   parameter int INDEX     = 0,
   parameter int POS_W     = 7,
   parameter int WORD_BITS = bol_pkg::WORD_BITS_DEF
) (
   input  wire                         clock,
   input  wire bol_pkg::cell_op_type   op,
   input  wire [POS_W-1:0]             target,
   input  wire [WORD_BITS-1:0]         data_word,
   input  wire [WORD_BITS-1:0]         lower_word,
   input  wire [WORD_BITS-1:0]         upper_word,
   input  wire [WORD_BITS-1:0]         upper_rd,
   output logic [WORD_BITS-1:0]        word,
   output logic [WORD_BITS-1:0]        rd
);
   import bol_pkg::*;

   localparam logic [POS_W-1:0] IDX = POS_W'(INDEX);

   logic [WORD_BITS-1:0] word_ff, word_in;
   logic [WORD_BITS-1:0] rd_ff, rd_in;
   logic                 at_target, above_target;

   assign at_target    = (IDX == target);
   assign above_target = (IDX > target);

   always_comb begin
      word_in = word_ff;
      rd_in   = rd_ff;
      unique case (op)
         CELL_WRITE: begin
            if (at_target) word_in = data_word;
         end
         CELL_INSERT: begin
            if (above_target) word_in = lower_word;
            else if (at_target) word_in = data_word;
         end
         CELL_ERASE: begin
            if (above_target || at_target) word_in = upper_word;
         end
         CELL_SNAP:     rd_in = word_ff;
         CELL_RD_SHIFT: rd_in = upper_rd;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      rd_ff   <= rd_in;
   end

   assign word = word_ff;
   assign rd   = rd_ff;

endmodule

`default_nettype wire

### rtl/bounded_ordered_list_unit.sv
// Top level of the bounded ordered list: command decode, element count and a chain
// of bol_cell storage cells. Depends on bol_pkg, bol_req_if, bol_rsp_if, bol_cell.
`default_nettype none

//  channel    direction  handshake        payload
//  req_chan   in         valid / ready    cmd, position, data_word
//  rsp_chan   out        valid / ready    read_word, element_count, error_code
//
//  For every command except a successful read, the chain of cells shifts, inserts or
//  writes, and the count updates, in the same cycle that the word is accepted.
//  A successful read holds the request side until its response is loaded, because
//  the element is copied into the read chain and moves one cell per cycle toward cell 0.
//  Reset is synchronous and clears the count, the read state and the response valid;
//  stored elements are not cleared and are only reachable once written.
//  The response sits in an output register, so a stalled response holds one result and
//  the next word is accepted in the cycle that the result is taken.

module bounded_ordered_list_unit #(
   parameter int CAPACITY  = bol_pkg::CAPACITY_DEF,
   parameter int WORD_BITS = bol_pkg::WORD_BITS_DEF
) (
   input  wire        clock,
   input  wire        reset,
   bol_req_if.sink    req_chan,
   bol_rsp_if.source  rsp_chan
);
   import bol_pkg::*;

   // Position and count share one width: wide enough to hold CAPACITY itself.
   localparam int POS_W = $clog2(CAPACITY + 1);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_READ = 1'b1;

   localparam logic [POS_W-1:0] FULL_COUNT = POS_W'(CAPACITY);
   localparam logic [POS_W-1:0] ONE        = POS_W'(1);

   // Control state.
   logic                  state_ff, state_in;
   logic [POS_W-1:0]      count_ff, count_in;
   logic [POS_W-1:0]      rd_cnt_ff, rd_cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // Response payload; no reset needed.
   logic [WORD_BITS-1:0]  read_word_ff, read_word_in;
   logic [POS_W-1:0]      elem_count_ff, elem_count_in;
   err_type               error_code_ff, error_code_in;

   // Broadcast to the cell chain.
   cell_op_type           cell_op;
   logic [POS_W-1:0]      cell_target;

   logic                  out_free;
   logic                  req_fire;
   logic                  rsp_load;
   logic                  pos_lt_count, pos_le_count, is_full, is_empty;

   logic [WORD_BITS-1:0]  words [CAPACITY];
   logic [WORD_BITS-1:0]  rds   [CAPACITY];

   // The output register is free when empty or when its word leaves this cycle.
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE) && out_free;
   assign req_fire = req_chan.valid && req_chan.ready;

   assign pos_lt_count = (req_chan.position <  count_ff);
   assign pos_le_count = (req_chan.position <= count_ff);
   assign is_full      = (count_ff == FULL_COUNT);
   assign is_empty     = (count_ff == '0);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      rd_cnt_in     = rd_cnt_ff;
      rsp_load      = 1'b0;
      read_word_in  = '0;
      error_code_in = ERR_OK;
      cell_op       = CELL_HOLD;
      cell_target   = req_chan.position;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               rsp_load = 1'b1;
               case (req_chan.cmd)
                  CMD_APPEND: begin
                     if (is_full) begin
                        error_code_in = ERR_FULL;
                     end else begin
                        cell_op     = CELL_WRITE;
                        cell_target = count_ff;
                        count_in    = count_ff + ONE;
                     end
                  end
                  CMD_REMOVE: begin
                     if (is_empty) error_code_in = ERR_EMPTY;
                     else count_in = count_ff - ONE;
                  end
                  CMD_INSERT: begin
                     // The range check wins over the full check.
                     if (!pos_le_count) begin
                        error_code_in = ERR_RANGE;
                     end else if (is_full) begin
                        error_code_in = ERR_FULL;
                     end else begin
                        cell_op  = CELL_INSERT;
                        count_in = count_ff + ONE;
                     end
                  end
                  CMD_ERASE: begin
                     if (!pos_lt_count) begin
                        error_code_in = ERR_RANGE;
                     end else begin
                        cell_op  = CELL_ERASE;
                        count_in = count_ff - ONE;
                     end
                  end
                  CMD_READ: begin
                     if (!pos_lt_count) begin
                        error_code_in = ERR_RANGE;
                     end else begin
                        // Copy all elements into the read chain, then walk the wanted
                        // one down to cell 0; the response waits for it.
                        rsp_load  = 1'b0;
                        cell_op   = CELL_SNAP;
                        rd_cnt_in = req_chan.position;
                        state_in  = ST_READ;
                     end
                  end
                  CMD_WRITE: begin
                     if (!pos_lt_count) error_code_in = ERR_RANGE;
                     else cell_op = CELL_WRITE;
                  end
                  CMD_CLEAR: count_in = '0;
                  default: ;
               endcase
            end
         end
         ST_READ: begin
            if (rd_cnt_ff != '0) begin
               cell_op   = CELL_RD_SHIFT;
               rd_cnt_in = rd_cnt_ff - ONE;
            end else if (out_free) begin
               rsp_load     = 1'b1;
               read_word_in = rds[0];
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // The reported count is always the count after the command.
   assign elem_count_in = count_in;

   always_comb begin
      if (rsp_load) rsp_valid_in = 1'b1;
      else if (rsp_chan.ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rd_cnt_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_cnt_ff    <= rd_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         read_word_ff  <= read_word_in;
         elem_count_ff <= elem_count_in;
         error_code_ff <= error_code_in;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.read_word     = read_word_ff;
   assign rsp_chan.element_count = elem_count_ff;
   assign rsp_chan.error_code    = error_code_ff;

   // The chain: cell i takes its lower neighbor on insert, its upper neighbor on erase,
   // and its upper neighbor's read stage while a read walks down.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [WORD_BITS-1:0] lower_word;
      logic [WORD_BITS-1:0] upper_word;
      logic [WORD_BITS-1:0] upper_rd;

      if (i == 0) begin : g_bottom
         assign lower_word = '0;
      end else begin : g_lower
         assign lower_word = words[i-1];
      end

      if (i == CAPACITY - 1) begin : g_top
         assign upper_word = '0;
         assign upper_rd   = '0;
      end else begin : g_upper
         assign upper_word = words[i+1];
         assign upper_rd   = rds[i+1];
      end

      bol_cell #(
         .INDEX     (i),
         .POS_W     (POS_W),
         .WORD_BITS (WORD_BITS)
      ) u_cell (
         .clock      (clock),
         .op         (cell_op),
         .target     (cell_target),
         .data_word  (req_chan.data_word),
         .lower_word (lower_word),
         .upper_word (upper_word),
         .upper_rd   (upper_rd),
         .word       (words[i]),
         .rd         (rds[i])
      );
   end

endmodule

`default_nettype wire
